FILE: hw/rtl/swhsr_pkg.sv
`default_nettype none

package swhsr_pkg;

  localparam logic [6:0] MAX_EDGES = 7'd85;
  localparam logic [5:0] FRAME_BITS = 6'd40;

  localparam logic [2:0] REG_SENSOR_KIND      = 3'd0;
  localparam logic [2:0] REG_ONE_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_START_LOW_TICKS  = 3'd2;
  localparam logic [2:0] REG_START_HIGH_TICKS = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_TICKS    = 3'd4;

  localparam logic KIND_DHT22 = 1'b1;

  typedef struct packed {
    logic start_request;
    logic line_level;
  } in_t;

  typedef struct packed {
    logic                drive_enable;
    logic                drive_level;
    logic                busy_res;
    logic                done_res;
    logic                good;
    logic [7:0]          humidity_integral;
    logic [7:0]          humidity_fraction;
    logic [7:0]          temperature_integral;
    logic [7:0]          temperature_fraction;
    logic [15:0]         humidity_tenths;
    logic signed [15:0]  temperature_tenths;
  } out_t;

  typedef struct packed {
    logic        sensor_kind;
    logic [7:0]  one_threshold;
    logic [14:0] start_low_ticks;
    logic [7:0]  start_high_ticks;
    logic [7:0]  timeout_ticks;
  } cfg_t;

  // one classified tick, bytes only filled on the closing tick
  typedef struct packed {
    logic            drive_enable;
    logic            drive_level;
    logic            busy;
    logic            done;
    logic            full;
    logic [4:0][7:0] bytes;
  } rec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/swhsr_front.sv
`default_nettype none

module swhsr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire swhsr_pkg::in_t  in_data,
  input  wire swhsr_pkg::cfg_t cfg,
  output swhsr_pkg::rec_t      rec
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  logic [1:0]      phase_r, phase_nxt;
  logic [14:0]     timer_r, timer_nxt;
  logic [7:0]      run_r, run_nxt;
  logic            prev_r, prev_nxt;
  logic [6:0]      edge_r, edge_nxt;
  logic [5:0]      bitcnt_r, bitcnt_nxt;
  logic [4:0][7:0] frame_r, frame_nxt;

  logic [1:0]      cur_phase;
  logic [14:0]     cur_timer;
  logic [5:0]      cur_bitcnt;
  logic [4:0][7:0] cur_frame;
  logic [14:0]     timer_inc;
  logic [7:0]      run_inc;
  logic [6:0]      edge_inc;
  logic            take;
  logic            bit_val;
  logic            done;

  always_comb begin
    cur_phase  = phase_r;
    cur_timer  = timer_r;
    cur_bitcnt = bitcnt_r;
    cur_frame  = frame_r;
    if (phase_r == PH_IDLE && in_data.start_request) begin
      cur_phase  = PH_LOW;
      cur_timer  = '0;
      cur_bitcnt = '0;
      cur_frame  = '0;
    end

    timer_inc = cur_timer + 15'd1;
    run_inc   = (run_r != 8'hFF) ? run_r + 8'd1 : run_r;
    edge_inc  = edge_r + 7'd1;
    bit_val   = run_r > cfg.one_threshold;

    phase_nxt  = cur_phase;
    timer_nxt  = cur_timer;
    run_nxt    = run_r;
    prev_nxt   = prev_r;
    edge_nxt   = edge_r;
    bitcnt_nxt = cur_bitcnt;
    take       = 1'b0;
    done       = 1'b0;
    rec        = '0;

    unique case (cur_phase)
      PH_LOW: begin
        rec.drive_enable = 1'b1;
        rec.busy         = 1'b1;
        timer_nxt        = timer_inc;
        if (timer_inc >= cfg.start_low_ticks || timer_inc == '0) begin
          phase_nxt = PH_HIGH;
          timer_nxt = '0;
        end
      end
      PH_HIGH: begin
        rec.drive_enable = 1'b1;
        rec.drive_level  = 1'b1;
        rec.busy         = 1'b1;
        timer_nxt        = timer_inc;
        if (timer_inc >= {7'd0, cfg.start_high_ticks}) begin
          phase_nxt = PH_MEAS;
          timer_nxt = '0;
          run_nxt   = '0;
          prev_nxt  = 1'b1;
          edge_nxt  = '0;
        end
      end
      PH_MEAS: begin
        rec.busy = 1'b1;
        if (in_data.line_level == prev_r) begin
          run_nxt = run_inc;
          done    = run_inc >= cfg.timeout_ticks;
        end else begin
          take     = edge_r >= 7'd4 && !edge_r[0] && cur_bitcnt < swhsr_pkg::FRAME_BITS;
          prev_nxt = in_data.line_level;
          run_nxt  = '0;
          edge_nxt = edge_inc;
          done     = edge_inc >= swhsr_pkg::MAX_EDGES;
        end
      end
      default: begin
      end
    endcase

    frame_nxt = cur_frame;
    for (int i = 0; i < 5; i++) begin
      if (take && cur_bitcnt[5:3] == 3'(i)) begin
        frame_nxt[4 - i] = {cur_frame[4 - i][6:0], bit_val};
      end
    end
    if (take) begin
      bitcnt_nxt = cur_bitcnt + 6'd1;
    end

    if (done) begin
      phase_nxt = PH_IDLE;
      rec.busy  = 1'b0;
      rec.done  = 1'b1;
      rec.full  = bitcnt_nxt >= swhsr_pkg::FRAME_BITS;
      rec.bytes = frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      timer_r  <= '0;
      run_r    <= '0;
      prev_r   <= 1'b1;
      edge_r   <= '0;
      bitcnt_r <= '0;
      frame_r  <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      timer_r  <= timer_nxt;
      run_r    <= run_nxt;
      prev_r   <= prev_nxt;
      edge_r   <= edge_nxt;
      bitcnt_r <= bitcnt_nxt;
      frame_r  <= frame_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/swhsr_queue.sv
`default_nettype none

module swhsr_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire swhsr_pkg::rec_t  push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output swhsr_pkg::rec_t       head
);

  swhsr_pkg::rec_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/swhsr_back.sv
`default_nettype none

module swhsr_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             sensor_kind,
  input  wire logic             q_not_empty,
  input  wire swhsr_pkg::rec_t  q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output swhsr_pkg::out_t       out_data
);

  logic             out_valid_r, out_valid_nxt;
  swhsr_pkg::out_t  out_data_r, out_data_nxt;
  logic [7:0]       sum;
  logic [14:0]      mag;
  logic             good;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sum  = q_head.bytes[4] + q_head.bytes[3] + q_head.bytes[2] + q_head.bytes[1];
    good = q_head.done && q_head.full && q_head.bytes[0] == sum;
    mag  = {q_head.bytes[2][6:0], q_head.bytes[1]};

    out_data_nxt                      = '0;
    out_data_nxt.drive_enable         = q_head.drive_enable;
    out_data_nxt.drive_level          = q_head.drive_level;
    out_data_nxt.busy_res             = q_head.busy;
    out_data_nxt.done_res             = q_head.done;
    out_data_nxt.good                 = good;
    out_data_nxt.humidity_integral    = q_head.bytes[4];
    out_data_nxt.humidity_fraction    = q_head.bytes[3];
    out_data_nxt.temperature_integral = q_head.bytes[2];
    out_data_nxt.temperature_fraction = q_head.bytes[1];
    if (good && sensor_kind == swhsr_pkg::KIND_DHT22) begin
      out_data_nxt.humidity_tenths = {q_head.bytes[4], q_head.bytes[3]};
      // sign-magnitude to two's complement
      out_data_nxt.temperature_tenths = q_head.bytes[2][7] ?
        16'(-{1'b0, mag}) : {1'b0, mag};
    end

    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/single_wire_humidity_sensor_reader.sv
`default_nettype none

// Reads a DHT11/DHT22 style sensor over its single data wire. Every accepted input is one
// microsecond sample of the line plus a start request; every accepted input yields exactly
// one result telling how to drive the line, whether a reading is in progress and, on the
// closing sample, the received bytes, the checksum verdict and (DHT22 mode) humidity and
// signed temperature in tenths. One sample is taken per clock while input is not stalled: the
// front tracker updates its run and edge counters on each accepted sample, and a result passes
// through a two-entry queue and the output register. Input stalls only when both the queue
// and the output register hold untaken results. No clearing pass is needed after reset.
// Registers written through cfg_index 0..4: sensor_kind, one_threshold, start_low_ticks,
// start_high_ticks, timeout_ticks; other indexes are ignored.
module single_wire_humidity_sensor_reader (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire swhsr_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output swhsr_pkg::out_t       out_data,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [14:0]      cfg_wdata
);

  swhsr_pkg::cfg_t cfg_r, cfg_nxt;
  swhsr_pkg::rec_t rec;
  swhsr_pkg::rec_t q_head;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        swhsr_pkg::REG_SENSOR_KIND:      cfg_nxt.sensor_kind      = cfg_wdata[0];
        swhsr_pkg::REG_ONE_THRESHOLD:    cfg_nxt.one_threshold    = cfg_wdata[7:0];
        swhsr_pkg::REG_START_LOW_TICKS:  cfg_nxt.start_low_ticks  = cfg_wdata;
        swhsr_pkg::REG_START_HIGH_TICKS: cfg_nxt.start_high_ticks = cfg_wdata[7:0];
        swhsr_pkg::REG_TIMEOUT_TICKS:    cfg_nxt.timeout_ticks    = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_kind      <= 1'b1;
      cfg_r.one_threshold    <= 8'd16;
      cfg_r.start_low_ticks  <= 15'd18000;
      cfg_r.start_high_ticks <= 8'd40;
      cfg_r.timeout_ticks    <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  swhsr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg_r),
    .rec     (rec)
  );

  swhsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  swhsr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .sensor_kind (cfg_r.sensor_kind),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // input only stalls behind a result that is still waiting
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no waiting result");

  a_good_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.good |-> out_data.done_res && !out_data.busy_res)
    else $error("good flagged outside a closing transfer");

  a_drive_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drive_level |-> out_data.drive_enable && out_data.busy_res)
    else $error("line driven high while not driving");

  a_tenths_need_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.good |-> out_data.humidity_tenths == '0 &&
      out_data.temperature_tenths == '0)
    else $error("tenths given without a good reading");

endmodule

`default_nettype wire
